[design/sit_pkg.sv]
`default_nettype none

package sit_pkg;

  // Widths of every coordinate field on the ports and of the tolerance register.
  localparam int unsigned FIELD_WIDTH     = 32;
  localparam int unsigned TOL_WIDTH       = 62;
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // Four segment endpoints and four orientation tests per item.
  localparam int unsigned NUM_PTS    = 4;
  localparam int unsigned NUM_ORIENT = 4;

  typedef logic [1:0] pt_idx_t;

  localparam pt_idx_t PT_A1 = 2'd0;  // first segment start
  localparam pt_idx_t PT_B1 = 2'd1;  // first segment end
  localparam pt_idx_t PT_A2 = 2'd2;  // second segment start
  localparam pt_idx_t PT_B2 = 2'd3;  // second segment end

  // Point triplets (p, q, r) of the four orientation tests. The bounding box
  // test that goes with each one checks r against the box spanned by p and q.
  localparam pt_idx_t TRI_P [NUM_ORIENT] = '{PT_A1, PT_A1, PT_A2, PT_A2};
  localparam pt_idx_t TRI_Q [NUM_ORIENT] = '{PT_B1, PT_B1, PT_B2, PT_B2};
  localparam pt_idx_t TRI_R [NUM_ORIENT] = '{PT_A2, PT_B2, PT_A1, PT_B1};

  typedef enum logic [1:0] {
    ORIENT_COL = 2'd0,
    ORIENT_CW  = 2'd1,
    ORIENT_CCW = 2'd2
  } orient_e;

endpackage

`default_nettype wire

[design/sit_front.sv]
`default_nettype none

module sit_front import sit_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [FIELD_WIDTH-1:0]        pt_north_i [NUM_PTS],
  input  logic [FIELD_WIDTH-1:0]        pt_east_i  [NUM_PTS],
  output logic signed [COORD_WIDTH:0]   x0_o       [NUM_ORIENT],
  output logic signed [COORD_WIDTH:0]   y0_o       [NUM_ORIENT],
  output logic signed [COORD_WIDTH:0]   x1_o       [NUM_ORIENT],
  output logic signed [COORD_WIDTH:0]   y1_o       [NUM_ORIENT],
  output logic [NUM_ORIENT-1:0]         box_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;

  logic signed [COORD_WIDTH-1:0] pn [NUM_PTS];
  logic signed [COORD_WIDTH-1:0] pe [NUM_PTS];

  logic signed [DW-1:0]  x0_d [NUM_ORIENT];
  logic signed [DW-1:0]  y0_d [NUM_ORIENT];
  logic signed [DW-1:0]  x1_d [NUM_ORIENT];
  logic signed [DW-1:0]  y1_d [NUM_ORIENT];
  logic [NUM_ORIENT-1:0] box_d;

  for (genvar i = 0; i < NUM_PTS; i++) begin : g_pt
    assign pn[i] = $signed(pt_north_i[i][COORD_WIDTH-1:0]);
    assign pe[i] = $signed(pt_east_i[i][COORD_WIDTH-1:0]);
  end

  // Operand differences of the cross product for triplet (p, q, r):
  // (q.e - p.e) * (r.n - q.n) - (q.n - p.n) * (r.e - q.e).
  for (genvar k = 0; k < NUM_ORIENT; k++) begin : g_tri
    localparam pt_idx_t P = TRI_P[k];
    localparam pt_idx_t Q = TRI_Q[k];
    localparam pt_idx_t R = TRI_R[k];

    assign x0_d[k] = DW'(pe[Q]) - DW'(pe[P]);
    assign y0_d[k] = DW'(pn[R]) - DW'(pn[Q]);
    assign x1_d[k] = DW'(pn[Q]) - DW'(pn[P]);
    assign y1_d[k] = DW'(pe[R]) - DW'(pe[Q]);

    // Point r lies inside the inclusive box spanned by p and q.
    assign box_d[k] = ((pn[R] <= pn[P]) || (pn[R] <= pn[Q]))
                   && ((pn[R] >= pn[P]) || (pn[R] >= pn[Q]))
                   && ((pe[R] <= pe[P]) || (pe[R] <= pe[Q]))
                   && ((pe[R] >= pe[P]) || (pe[R] >= pe[Q]));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_o  <= x0_d;
      y0_o  <= y0_d;
      x1_o  <= x1_d;
      y1_o  <= y1_d;
      box_o <= box_d;
    end
  end

endmodule

`default_nettype wire

[design/sit_orient.sv]
`default_nettype none

module sit_orient import sit_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [COORD_WIDTH:0] x0_i,
  input  logic signed [COORD_WIDTH:0] y0_i,
  input  logic signed [COORD_WIDTH:0] x1_i,
  input  logic signed [COORD_WIDTH:0] y1_i,
  input  logic [TOL_WIDTH-1:0]        tol_i,
  output orient_e                     cls_o
);

  localparam int unsigned PROD_W = 2 * COORD_WIDTH + 2;
  localparam int unsigned VAL_W  = PROD_W + 1;
  localparam int unsigned CMP_W  = (VAL_W > TOL_WIDTH + 1) ? VAL_W : TOL_WIDTH + 1;

  logic signed [PROD_W-1:0] prod0_q, prod1_q;
  logic signed [VAL_W-1:0]  val_d, val_q;
  logic signed [CMP_W-1:0]  val_ext, tol_pos, tol_neg;
  logic                     col;
  orient_e                  cls_d;

  // Stage 2: both products, each one multiplier.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod0_q <= PROD_W'(x0_i) * PROD_W'(y0_i);
      prod1_q <= PROD_W'(x1_i) * PROD_W'(y1_i);
    end
  end

  // Stage 3: exact cross product.
  assign val_d = VAL_W'(prod0_q) - VAL_W'(prod1_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

  // Stage 4: collinear when -tol <= val <= tol, otherwise the sign decides.
  assign val_ext = CMP_W'(val_q);
  assign tol_pos = $signed(CMP_W'(tol_i));
  assign tol_neg = -tol_pos;
  assign col     = (val_ext <= tol_pos) && (val_ext >= tol_neg);

  always_comb begin
    if (col) begin
      cls_d = ORIENT_COL;
    end else if (val_q > 0) begin
      cls_d = ORIENT_CW;
    end else begin
      cls_d = ORIENT_CCW;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cls_o <= cls_d;
    end
  end

endmodule

`default_nettype wire

[design/segment_intersection_test.sv]
// Segment intersection test by orientation cross products.
// The input channel (in_valid_i / in_ready_o) carries one item: the start and
// end points of two segments as signed north/east coordinates. Only the low
// COORD_WIDTH bits of each field are used. The output channel (out_valid_o /
// out_ready_i) returns one item per input item, the segments_intersect flag.
// The pipeline has five register stages: operand differences and bounding box
// compares, products, cross products, tolerance classing, and the final flag.
// With no stall, a new item is accepted in every cycle. All stages advance
// together; when the output holds an item the receiver has not taken, the
// whole pipeline holds and in_ready_o drops, so nothing is lost or repeated.
// The stall path from out_ready_i to in_ready_o is combinational.
// The collinear tolerance is written through cfg_we_i / cfg_wdata_i and should
// only change while no item is in flight.
// Reset clears all valid bits and sets the tolerance to zero; no clearing pass
// is needed, so an item may be accepted right after reset.
`default_nettype none

module segment_intersection_test import sit_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [FIELD_WIDTH-1:0] first_start_north_i,
  input  logic [FIELD_WIDTH-1:0] first_start_east_i,
  input  logic [FIELD_WIDTH-1:0] first_end_north_i,
  input  logic [FIELD_WIDTH-1:0] first_end_east_i,
  input  logic [FIELD_WIDTH-1:0] second_start_north_i,
  input  logic [FIELD_WIDTH-1:0] second_start_east_i,
  input  logic [FIELD_WIDTH-1:0] second_end_north_i,
  input  logic [FIELD_WIDTH-1:0] second_end_east_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   segments_intersect_o,
  input  logic                   cfg_we_i,
  input  logic [TOL_WIDTH-1:0]   cfg_wdata_i
);

  logic [FIELD_WIDTH-1:0] pt_north [NUM_PTS];
  logic [FIELD_WIDTH-1:0] pt_east  [NUM_PTS];

  logic signed [COORD_WIDTH:0] x0 [NUM_ORIENT];
  logic signed [COORD_WIDTH:0] y0 [NUM_ORIENT];
  logic signed [COORD_WIDTH:0] x1 [NUM_ORIENT];
  logic signed [COORD_WIDTH:0] y1 [NUM_ORIENT];
  logic [NUM_ORIENT-1:0]       box_s1;
  orient_e                     cls [NUM_ORIENT];

  logic [TOL_WIDTH-1:0]  tol_q;
  logic                  en;
  logic                  v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic [NUM_ORIENT-1:0] box_s2_q, box_s3_q, box_s4_q;
  logic                  straddle, touch;
  logic                  hit_d, hit_q;

  assign pt_north[PT_A1] = first_start_north_i;
  assign pt_east[PT_A1]  = first_start_east_i;
  assign pt_north[PT_B1] = first_end_north_i;
  assign pt_east[PT_B1]  = first_end_east_i;
  assign pt_north[PT_A2] = second_start_north_i;
  assign pt_east[PT_A2]  = second_start_east_i;
  assign pt_north[PT_B2] = second_end_north_i;
  assign pt_east[PT_B2]  = second_end_east_i;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  sit_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .en_i       (en),
    .pt_north_i (pt_north),
    .pt_east_i  (pt_east),
    .x0_o       (x0),
    .y0_o       (y0),
    .x1_o       (x1),
    .y1_o       (y1),
    .box_o      (box_s1)
  );

  for (genvar k = 0; k < NUM_ORIENT; k++) begin : g_orient
    sit_orient #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_orient (
      .clk_i (clk_i),
      .en_i  (en),
      .x0_i  (x0[k]),
      .y0_i  (y0[k]),
      .x1_i  (x1[k]),
      .y1_i  (y1[k]),
      .tol_i (tol_q),
      .cls_o (cls[k])
    );
  end

  // The box flags ride alongside the three stages of the orientation units.
  always_ff @(posedge clk_i) begin
    if (en) begin
      box_s2_q <= box_s1;
      box_s3_q <= box_s2_q;
      box_s4_q <= box_s3_q;
    end
  end

  // The segments cross when each one separates the ends of the other. They
  // also touch when a collinear endpoint falls inside the other segment's box.
  assign straddle = (cls[0] != cls[1]) && (cls[2] != cls[3]);

  always_comb begin
    touch = 1'b0;
    for (int k = 0; k < NUM_ORIENT; k++) begin
      touch = touch || ((cls[k] == ORIENT_COL) && box_s4_q[k]);
    end
  end

  assign hit_d = straddle || touch;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign segments_intersect_o = hit_q;

endmodule

`default_nettype wire

[design/sit_checker.sv]
`default_nettype none

module sit_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic segments_intersect_o
);

  // A result that waits keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(segments_intersect_o))
    else $error("result changed while stalled");

  // A stalled result holds the whole pipeline, so no item may enter.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("item accepted while output stalled");

  // An empty output register always lets an item in.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // A new result only shows up after the pipeline has advanced.
  a_rise_after_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("result appeared without pipeline advance");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (.*);

`default_nettype wire
